>>> rtl/core/scjr_pkg.sv
// shared types, constants and command tables for the camera capture reader
`timescale 1ns / 1ps

package scjr_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam logic [15:0] MIN_CHUNK = 16'd32;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // finish status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ACK_BAD = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_HDR_BAD = 2'd3;

  // register indexes
  localparam logic [1:0] REG_CHUNK   = 2'd0;
  localparam logic [1:0] REG_REPLY   = 2'd1;
  localparam logic [1:0] REG_TAIL    = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  byte_value;
    logic [1:0]  finish_status;
    logic [31:0] image_length;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [15:0] chunk_req;
    logic [15:0] reply_to;
    logic [15:0] tail_to;
  } cfg_t;

  typedef enum logic [2:0] {
    BURST_CAP,
    BURST_LEN,
    BURST_RES,
    BURST_READ,
    BURST_DATA,
    BURST_FIN
  } burst_t;

  // one step's worth of results, expanded by the emitter
  typedef struct packed {
    logic        emit;
    burst_t      kind;
    logic [7:0]  value;
    logic [1:0]  status;
    logic [31:0] length;
    logic [31:0] addr;
    logic [15:0] count;
  } desc_t;

  function automatic logic [7:0] ack_freeze_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h76;
      3'd2:    b = 8'h36;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ack_header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h76;
      3'd2:    b = 8'h32;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // five-byte commands: capture, length, resume differ in bytes two and four
  function automatic logic [7:0] short_cmd_byte(input burst_t kind, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0: b = 8'h56;
      4'd2: b = (kind == BURST_LEN) ? 8'h34 : 8'h36;
      4'd3: b = 8'h01;
      4'd4: b = (kind == BURST_RES) ? 8'h03 : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] read_cmd_byte(input logic [31:0] addr,
                                               input logic [15:0] count,
                                               input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:  b = 8'h56;
      4'd2:  b = 8'h32;
      4'd3:  b = 8'h0C;
      4'd5:  b = 8'h0A;
      4'd6:  b = addr[31:24];
      4'd7:  b = addr[23:16];
      4'd8:  b = addr[15:8];
      4'd9:  b = addr[7:0];
      4'd12: b = count[15:8];
      4'd13: b = count[7:0];
      4'd15: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/scjr_regs.sv
// configuration registers behind the apb port
`timescale 1ns / 1ps

module scjr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scjr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output scjr_pkg::cfg_t              cfg
);
  import scjr_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_req <= 16'd1024;
      cfg.reply_to  <= 16'd1000;
      cfg.tail_to   <= 16'd100;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_CHUNK: cfg.chunk_req <= pwdata[15:0];
        REG_REPLY: cfg.reply_to  <= pwdata[15:0];
        REG_TAIL:  cfg.tail_to   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHUNK: prdata = {16'd0, cfg.chunk_req};
      REG_REPLY: prdata = {16'd0, cfg.reply_to};
      REG_TAIL:  prdata = {16'd0, cfg.tail_to};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/scjr_ctrl.sv
// protocol sequencer: one step per request, producing a burst descriptor
`timescale 1ns / 1ps

module scjr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  scjr_pkg::req_t item,
  input  scjr_pkg::cfg_t cfg,
  output scjr_pkg::desc_t desc
);
  import scjr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CAP_ACK,
    PH_LEN,
    PH_HDR,
    PH_DATA,
    PH_TAIL,
    PH_RES_ACK
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] cnt, cnt_next;
  logic [31:0] total, total_next;
  logic [31:0] addr, addr_next;
  logic [31:0] rem, rem_next;        // bytes left after the chunk in flight
  logic [15:0] chunk, chunk_next;
  logic [15:0] timer, timer_next;
  logic [1:0]  pend, pend_next;
  logic        mism, mism_next;

  logic [15:0] cnt_inc, timer_inc, eff_raw, eff, n;
  logic        mism_now;
  logic        do_enter, do_finish, do_resume, do_next;
  phase_t      enter_ph;
  logic [1:0]  resume_st;
  logic [31:0] nc_addr, nc_rem;

  always_comb begin
    eff_raw   = (cfg.chunk_req < MIN_CHUNK) ? MIN_CHUNK : cfg.chunk_req;
    eff       = {eff_raw[15:3], 3'b000};
    cnt_inc   = cnt + 16'd1;
    timer_inc = (timer == 16'hFFFF) ? timer : timer + 16'd1;
    mism_now  = 1'b0;

    phase_next = phase;
    cnt_next   = cnt;
    total_next = total;
    addr_next  = addr;
    rem_next   = rem;
    chunk_next = chunk;
    timer_next = timer;
    pend_next  = pend;
    mism_next  = mism;

    do_enter  = 1'b0;
    enter_ph  = phase;
    do_finish = 1'b0;
    do_resume = 1'b0;
    resume_st = pend;
    do_next   = 1'b0;
    nc_addr   = addr;
    nc_rem    = rem;
    n         = 16'd0;

    desc        = '0;
    desc.kind   = BURST_FIN;

    case (item.req_type)
      REQ_START: begin
        if (phase == PH_IDLE) begin
          total_next = 32'd0;
          addr_next  = 32'd0;
          rem_next   = 32'd0;
          chunk_next = 16'd0;
          pend_next  = ST_OK;
          desc.emit  = 1'b1;
          desc.kind  = BURST_CAP;
          do_enter   = 1'b1;
          enter_ph   = PH_CAP_ACK;
        end
      end
      REQ_BYTE: begin
        unique case (phase)
          PH_CAP_ACK: begin
            mism_now   = mism || (item.rx_byte != ack_freeze_byte(cnt[2:0]));
            cnt_next   = cnt_inc;
            mism_next  = mism_now;
            timer_next = 16'd0;
            if (cnt_inc >= 16'd5) begin
              if (mism_now) begin
                pend_next = ST_ACK_BAD;
                do_finish = 1'b1;
              end else begin
                desc.emit = 1'b1;
                desc.kind = BURST_LEN;
                do_enter  = 1'b1;
                enter_ph  = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (cnt >= 16'd5) total_next = {total[23:0], item.rx_byte};
            cnt_next   = cnt_inc;
            timer_next = 16'd0;
            if (cnt_inc >= 16'd9) begin
              do_next = 1'b1;
              nc_rem  = total_next;
            end
          end
          PH_HDR: begin
            mism_now   = mism || (item.rx_byte != ack_header_byte(cnt[2:0]));
            cnt_next   = cnt_inc;
            mism_next  = mism_now;
            timer_next = 16'd0;
            if (cnt_inc >= 16'd5) begin
              if (mism_now) begin
                do_resume = 1'b1;
                resume_st = ST_HDR_BAD;
              end else begin
                do_enter = 1'b1;
                enter_ph = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            desc.emit  = 1'b1;
            desc.kind  = BURST_DATA;
            desc.value = item.rx_byte;
            cnt_next   = cnt_inc;
            timer_next = 16'd0;
            if (cnt_inc >= chunk) begin
              do_enter = 1'b1;
              enter_ph = PH_TAIL;
            end
          end
          PH_TAIL: begin
            cnt_next = cnt_inc;
            if (cnt_inc >= 16'd5) begin
              do_next = 1'b1;
              nc_addr = addr + {16'd0, chunk};
            end
          end
          PH_RES_ACK: begin
            cnt_next   = cnt_inc;
            timer_next = 16'd0;
            if (cnt_inc >= 16'd5) do_finish = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (phase == PH_TAIL) begin
          // tail expiry counts as a complete tail
          if (timer_inc >= cfg.tail_to) begin
            do_next = 1'b1;
            nc_addr = addr + {16'd0, chunk};
          end else begin
            timer_next = timer_inc;
          end
        end else if (phase != PH_IDLE) begin
          if (timer_inc < cfg.reply_to) begin
            timer_next = timer_inc;
          end else begin
            unique case (phase)
              PH_CAP_ACK, PH_LEN: begin
                pend_next = ST_TIMEOUT;
                do_finish = 1'b1;
              end
              PH_HDR, PH_DATA: begin
                do_resume = 1'b1;
                resume_st = ST_TIMEOUT;
              end
              default: do_finish = 1'b1;
            endcase
          end
        end
      end
      default: ;
    endcase

    // next chunk when bytes remain, otherwise resume
    if (do_next) begin
      addr_next = nc_addr;
      if (nc_rem != 32'd0) begin
        n          = (nc_rem > {16'd0, eff}) ? eff : nc_rem[15:0];
        chunk_next = n;
        rem_next   = nc_rem - {16'd0, n};
        desc.emit  = 1'b1;
        desc.kind  = BURST_READ;
        desc.addr  = nc_addr;
        desc.count = n;
        do_enter   = 1'b1;
        enter_ph   = PH_HDR;
      end else begin
        do_resume = 1'b1;
        resume_st = pend;
      end
    end

    if (do_resume) begin
      pend_next = resume_st;
      desc.emit = 1'b1;
      desc.kind = BURST_RES;
      do_enter  = 1'b1;
      enter_ph  = PH_RES_ACK;
    end

    if (do_finish) begin
      desc.emit   = 1'b1;
      desc.kind   = BURST_FIN;
      desc.status = pend_next;
      do_enter    = 1'b1;
      enter_ph    = PH_IDLE;
    end

    if (do_enter) begin
      phase_next = enter_ph;
      cnt_next   = 16'd0;
      timer_next = 16'd0;
      mism_next  = 1'b0;
    end

    desc.length = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= 16'd0;
      total <= 32'd0;
      addr  <= 32'd0;
      rem   <= 32'd0;
      chunk <= 16'd0;
      timer <= 16'd0;
      pend  <= ST_OK;
      mism  <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      total <= total_next;
      addr  <= addr_next;
      rem   <= rem_next;
      chunk <= chunk_next;
      timer <= timer_next;
      pend  <= pend_next;
      mism  <= mism_next;
    end
  end

endmodule

>>> rtl/core/scjr_emit.sv
// result register: expands one burst descriptor into result transfers
`timescale 1ns / 1ps

module scjr_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  scjr_pkg::desc_t desc_in,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output scjr_pkg::res_t  out_item
);
  import scjr_pkg::*;

  desc_t      desc;
  logic       busy;
  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       at_last, fire;

  always_comb begin
    case (desc.kind)
      BURST_CAP, BURST_LEN, BURST_RES: last_idx = 4'd4;
      BURST_READ:                      last_idx = 4'd15;
      default:                         last_idx = 4'd0;
    endcase
  end

  assign at_last   = (idx == last_idx);
  assign fire      = busy && !out_stall;
  assign free      = !busy || (fire && at_last);
  assign out_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 4'd0;
    end else if (fire) begin
      if (at_last) busy <= 1'b0;
      else idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc <= desc_in;
  end

  always_comb begin
    out_item.finish_status = ST_OK;
    out_item.image_length  = desc.length;
    out_item.last_of_run   = at_last;
    case (desc.kind)
      BURST_READ: begin
        out_item.item_kind  = KIND_SEND;
        out_item.byte_value = read_cmd_byte(desc.addr, desc.count, idx);
      end
      BURST_DATA: begin
        out_item.item_kind  = KIND_DATA;
        out_item.byte_value = desc.value;
      end
      BURST_FIN: begin
        out_item.item_kind     = KIND_FINISH;
        out_item.byte_value    = 8'h00;
        out_item.finish_status = desc.status;
      end
      default: begin
        out_item.item_kind  = KIND_SEND;
        out_item.byte_value = short_cmd_byte(desc.kind, idx);
      end
    endcase
  end

endmodule

>>> rtl/core/serial_camera_jpeg_capture_reader_unit.sv
// top level of the serial camera capture reader
`timescale 1ns / 1ps
// an item is registered at its transfer; its first result is shown the cycle after the item
//   leaves the input register
// throughput: one item per cycle while each causes at most one result and no out_stall; an item
//   with k results holds the result register for k transfers (5 per command, 16 per chunk read)
// reset: synchronous, clears the sequencer to idle and loads register defaults; no clearing pass

module serial_camera_jpeg_capture_reader_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  scjr_pkg::req_t              in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output scjr_pkg::res_t              out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scjr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import scjr_pkg::*;

  cfg_t  cfg;
  desc_t desc;
  req_t  in_q;
  logic  in_q_valid;
  logic  free, step;

  scjr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scjr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .cfg  (cfg),
    .desc (desc)
  );

  scjr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (step && desc.emit),
    .desc_in   (desc),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // items with no results never wait for the result register
  assign step     = in_q_valid && (!desc.emit || free);
  assign in_stall = in_q_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_q <= in_item;
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with empty input register");

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.item_kind == KIND_FINISH) |-> out_item.last_of_run)
    else $error("finish result not last of its run");

  a_data_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.item_kind == KIND_DATA) |->
      (out_item.last_of_run && out_item.finish_status == ST_OK))
    else $error("data result malformed");

  a_status_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.item_kind != KIND_FINISH) |-> out_item.finish_status == ST_OK)
    else $error("status set on a non-finish result");

endmodule

>>> tb/serial_camera_jpeg_capture_reader_unit_tb.sv
// self-checking testbench for the serial camera capture reader
`timescale 1ns / 1ps

module serial_camera_jpeg_capture_reader_unit_tb;
  import scjr_pkg::*;

  localparam logic [1:0] REQ_NONE  = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [39:0] FREEZE_CMD   = 40'h56_00_36_01_00;
  localparam logic [39:0] SIZE_REQ_CMD = 40'h56_00_34_01_00;
  localparam logic [39:0] RESUME_CMD   = 40'h56_00_36_01_03;
  localparam logic [39:0] FREEZE_ACK  = 40'h76_00_36_00_00;
  localparam logic [39:0] HEADER_ACK  = 40'h76_00_32_00_00;
  localparam logic [47:0] READ_HEAD   = 48'h56_00_32_0C_00_0A;
  localparam logic [15:0] READ_TAIL   = 16'h00_0A;

  localparam int LONG_HOLD = 400;
  localparam int MAX_PER_STEP = 16;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_CAP_ACK, SEQ_LEN, SEQ_HDR, SEQ_DATA, SEQ_TAIL, SEQ_RES_ACK
  } seq_t;

  typedef enum logic [2:0] {
    SC_GOOD, SC_ACK_BAD, SC_TO_ACK, SC_TO_LEN, SC_HDR_BAD, SC_TO_HDR, SC_TO_DATA, SC_TO_RES
  } scen_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_camera_jpeg_capture_reader_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // reader state as seen from the host side
  logic [15:0] cfg_chunk, cfg_reply, cfg_tail;
  seq_t        rd_phase;
  logic [15:0] byte_cnt;
  logic [31:0] img_len;
  logic [31:0] rd_addr;
  logic [15:0] chunk_len;
  logic [15:0] wait_ticks;
  logic [1:0]  run_status;
  bit          reply_bad;

  res_t step_q[$];
  res_t host_out_q[$];
  req_t camera_events_q[$];

  int  fail_count = 0;
  int  n_results = 0;
  int  n_events = 0;
  int  scen_rot = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  long_hold_done = 1'b0;

  function automatic logic [7:0] pat_byte(input logic [39:0] pat, input int i);
    return pat[39 - 8*i -: 8];
  endfunction

  function automatic void put_result(input logic [1:0] kind, input logic [7:0] val,
                                     input logic [1:0] st);
    res_t r;
    if (step_q.size() >= MAX_PER_STEP) return;
    r.item_kind = kind;
    r.byte_value = val;
    r.finish_status = st;
    r.image_length = img_len;
    r.last_of_run = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void seq_enter(input seq_t p);
    rd_phase = p;
    byte_cnt = '0;
    wait_ticks = '0;
    reply_bad = 1'b0;
  endfunction

  function automatic void send_cmd5(input logic [39:0] cmd);
    for (int i = 0; i < 5; i++) put_result(KIND_SEND, pat_byte(cmd, i), ST_OK);
  endfunction

  function automatic void seq_finish();
    put_result(KIND_FINISH, 8'h00, run_status);
    seq_enter(SEQ_IDLE);
  endfunction

  function automatic void start_resume(input logic [1:0] st);
    run_status = st;
    send_cmd5(RESUME_CMD);
    seq_enter(SEQ_RES_ACK);
  endfunction

  function automatic void issue_read();
    logic [31:0]  eff, left, n;
    logic [127:0] cmd;
    eff = {16'h0, cfg_chunk};
    if (eff < {16'h0, MIN_CHUNK}) eff = {16'h0, MIN_CHUNK};
    eff[2:0] = 3'b000;
    left = img_len - rd_addr;
    n = (left > eff) ? eff : left;
    chunk_len = n[15:0];
    cmd = {READ_HEAD, rd_addr, n, READ_TAIL};
    for (int i = 0; i < 16; i++) put_result(KIND_SEND, cmd[127 - 8*i -: 8], ST_OK);
    seq_enter(SEQ_HDR);
  endfunction

  function automatic void chunk_or_resume();
    if (rd_addr < img_len) issue_read();
    else start_resume(run_status);
  endfunction

  function automatic void tail_complete();
    rd_addr = rd_addr + {16'h0, chunk_len};
    chunk_or_resume();
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    case (rd_phase)
      SEQ_CAP_ACK: begin
        if (b != pat_byte(FREEZE_ACK, int'(byte_cnt))) reply_bad = 1'b1;
        byte_cnt++;
        wait_ticks = '0;
        if (byte_cnt >= 5) begin
          if (reply_bad) begin
            run_status = ST_ACK_BAD;
            seq_finish();
          end else begin
            send_cmd5(SIZE_REQ_CMD);
            seq_enter(SEQ_LEN);
          end
        end
      end
      SEQ_LEN: begin
        // first five reply bytes are not checked, the last four carry the length
        if (byte_cnt >= 5) img_len = {img_len[23:0], b};
        byte_cnt++;
        wait_ticks = '0;
        if (byte_cnt >= 9) chunk_or_resume();
      end
      SEQ_HDR: begin
        if (b != pat_byte(HEADER_ACK, int'(byte_cnt))) reply_bad = 1'b1;
        byte_cnt++;
        wait_ticks = '0;
        if (byte_cnt >= 5) begin
          if (reply_bad) start_resume(ST_HDR_BAD);
          else seq_enter(SEQ_DATA);
        end
      end
      SEQ_DATA: begin
        put_result(KIND_DATA, b, ST_OK);
        byte_cnt++;
        wait_ticks = '0;
        if (byte_cnt >= chunk_len) seq_enter(SEQ_TAIL);
      end
      SEQ_TAIL: begin
        byte_cnt++;
        if (byte_cnt >= 5) tail_complete();
      end
      SEQ_RES_ACK: begin
        byte_cnt++;
        wait_ticks = '0;
        if (byte_cnt >= 5) seq_finish();
      end
      default: ;
    endcase
  endfunction

  function automatic void take_tick();
    if (rd_phase == SEQ_IDLE) return;
    if (wait_ticks != 16'hFFFF) wait_ticks++;
    // tail expiry completes the tail: next chunk, or resume when no bytes remain
    if (rd_phase == SEQ_TAIL) begin
      if (wait_ticks >= cfg_tail) tail_complete();
      return;
    end
    if (wait_ticks < cfg_reply) return;
    case (rd_phase)
      SEQ_CAP_ACK, SEQ_LEN: begin
        run_status = ST_TIMEOUT;
        seq_finish();
      end
      SEQ_HDR, SEQ_DATA: start_resume(ST_TIMEOUT);
      default: seq_finish();
    endcase
  endfunction

  function automatic void reader_step(input req_t e);
    res_t r;
    step_q.delete();
    case (e.req_type)
      REQ_START: begin
        if (rd_phase == SEQ_IDLE) begin
          img_len = '0;
          rd_addr = '0;
          chunk_len = '0;
          run_status = ST_OK;
          send_cmd5(FREEZE_CMD);
          seq_enter(SEQ_CAP_ACK);
        end
      end
      REQ_BYTE: take_byte(e.rx_byte);
      REQ_TICK: take_tick();
      default: ;
    endcase
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.last_of_run = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) host_out_q.push_back(step_q[i]);
  endfunction

  function automatic void reader_reset();
    cfg_chunk = 16'd1024;
    cfg_reply = 16'd1000;
    cfg_tail = 16'd100;
    img_len = '0;
    rd_addr = '0;
    chunk_len = '0;
    run_status = ST_OK;
    seq_enter(SEQ_IDLE);
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sender: one event per transfer, random gaps after each
  always @(posedge clk) begin : drive
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) reader_step(in_item);
      if (tx_wait != 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (camera_events_q.size() != 0) begin
        if ($urandom_range(0, 99) < 3) tx_calm = !tx_calm;
        in_item <= camera_events_q.pop_front();
        in_valid <= 1'b1;
        tx_wait <= idle_len(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  always @(posedge clk) begin : hold
    int g;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else if (!long_hold_done && n_results >= 30) begin
      out_stall <= 1'b1;
      rx_wait <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 3) rx_calm = !rx_calm;
      g = idle_len(rx_calm);
      out_stall <= (g != 0);
      rx_wait <= (g != 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (host_out_q.size() == 0) begin
        $display("%0t ns: unexpected transfer, expected none, got kind %0d value 'h%0h",
                 $time, out_item.item_kind, out_item.byte_value);
        fail_count++;
      end else begin
        want = host_out_q.pop_front();
        check_field("item_kind", 32'(want.item_kind), 32'(out_item.item_kind));
        check_field("byte_value", 32'(want.byte_value), 32'(out_item.byte_value));
        check_field("finish_status", 32'(want.finish_status),
                    32'(out_item.finish_status));
        check_field("image_length", want.image_length, out_item.image_length);
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_item.last_of_run));
      end
    end
  end

  task automatic add_event(input logic [1:0] kind, input int b);
    req_t e;
    e.req_type = kind;
    e.rx_byte = 8'(b);
    camera_events_q.push_back(e);
    n_events++;
  endtask

  task automatic add_ticks(input int cnt);
    repeat (cnt) add_event(REQ_TICK, $urandom_range(0, 255));
  endtask

  // ticks short of a timeout, and requests the busy reader must ignore
  task automatic add_noise();
    int r, k;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      k = $urandom_range(0, 3);
      if (k > int'(cfg_reply) - 1) k = int'(cfg_reply) - 1;
      add_ticks(k);
    end else if (r < 19) begin
      add_event(REQ_START, $urandom_range(0, 255));
    end else if (r < 23) begin
      add_event(REQ_NONE, $urandom_range(0, 255));
    end
  endtask

  task automatic run_session(input scen_t sc);
    logic [31:0] len, eff, n, addr;
    logic [7:0]  b;
    int bad_at, k, kmax, i;
    add_event(REQ_START, $urandom_range(0, 255));
    if (sc == SC_TO_ACK) begin
      k = $urandom_range(0, 4);
      for (i = 0; i < k; i++) add_event(REQ_BYTE, pat_byte(FREEZE_ACK, i));
      add_ticks(int'(cfg_reply));
      return;
    end
    bad_at = (sc == SC_ACK_BAD) ? $urandom_range(0, 4) : 5;
    for (i = 0; i < 5; i++) begin
      add_noise();
      b = pat_byte(FREEZE_ACK, i);
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      add_event(REQ_BYTE, b);
    end
    if (sc == SC_ACK_BAD) return;
    if (sc == SC_TO_LEN) begin
      k = $urandom_range(0, 8);
      for (i = 0; i < k; i++) add_event(REQ_BYTE, $urandom_range(0, 255));
      add_ticks(int'(cfg_reply));
      return;
    end
    // aborted transfers may claim any length, complete ones stay short
    if (sc == SC_HDR_BAD || sc == SC_TO_HDR || sc == SC_TO_DATA) begin
      len = $urandom;
      if (len == 0) len = 1;
    end else if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(33, 40);
    end else begin
      len = $urandom_range(0, 6);
    end
    for (i = 0; i < 9; i++) begin
      add_noise();
      b = (i < 5) ? 8'($urandom_range(0, 255)) : len[8*(8-i)+7 -: 8];
      add_event(REQ_BYTE, b);
    end
    eff = {16'h0, cfg_chunk};
    if (eff < {16'h0, MIN_CHUNK}) eff = {16'h0, MIN_CHUNK};
    eff[2:0] = 3'b000;
    addr = '0;
    while (addr < len) begin
      n = (len - addr > eff) ? eff : len - addr;
      if (sc == SC_TO_HDR) begin
        k = $urandom_range(0, 4);
        for (i = 0; i < k; i++) add_event(REQ_BYTE, pat_byte(HEADER_ACK, i));
        add_ticks(int'(cfg_reply));
        break;
      end
      bad_at = (sc == SC_HDR_BAD) ? $urandom_range(0, 4) : 5;
      for (i = 0; i < 5; i++) begin
        add_noise();
        b = pat_byte(HEADER_ACK, i);
        if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
        add_event(REQ_BYTE, b);
      end
      if (sc == SC_HDR_BAD) break;
      if (sc == SC_TO_DATA) begin
        kmax = (n > 20) ? 20 : int'(n) - 1;
        k = $urandom_range(0, kmax);
        for (i = 0; i < k; i++) add_event(REQ_BYTE, $urandom_range(0, 255));
        add_ticks(int'(cfg_reply));
        break;
      end
      for (i = 0; i < n; i++) begin
        add_noise();
        add_event(REQ_BYTE, $urandom_range(0, 255));
      end
      // tail bytes do not restart the tail timer
      if (cfg_tail <= 8 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, 4);
        for (i = 0; i < k; i++) add_event(REQ_BYTE, $urandom_range(0, 255));
        add_ticks(int'(cfg_tail));
      end else begin
        for (i = 0; i < 5; i++) add_event(REQ_BYTE, $urandom_range(0, 255));
      end
      addr = addr + n;
    end
    if (sc == SC_TO_RES) begin
      add_ticks(int'(cfg_reply));
    end else begin
      for (i = 0; i < 5; i++) begin
        add_noise();
        add_event(REQ_BYTE, $urandom_range(0, 255));
      end
    end
  endtask

  function automatic scen_t pick_scenario();
    scen_t s;
    bit    ok;
    do begin
      s = scen_t'(scen_rot);
      scen_rot = (scen_rot + 1) % 8;
      // timeout cases only where the timeout is a handful of ticks
      ok = (cfg_reply <= 8) || s == SC_GOOD || s == SC_ACK_BAD || s == SC_HDR_BAD;
    end while (!ok);
    return s;
  endfunction

  task automatic random_phase(input int budget);
    int first;
    first = n_events;
    while (n_events - first < budget) run_session(pick_scenario());
  endtask

  task automatic wait_quiet();
    while (camera_events_q.size() != 0 || in_valid || host_out_q.size() != 0)
      @(posedge clk);
    // ticks and ignored requests leave nothing behind to wait for
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] word;
    word = $urandom;
    word[15:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHUNK: cfg_chunk = val;
      REG_REPLY: cfg_reply = val;
      REG_TAIL:  cfg_tail = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int i;
    reader_reset();
    scen_rot = $urandom_range(0, 7);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // idle reader ignores bytes, ticks and the unused request code
    add_event(REQ_BYTE, 8'hFF);
    add_event(REQ_TICK, 8'h00);
    add_event(REQ_NONE, 8'hA5);
    // second start while busy is dropped
    add_event(REQ_START, 8'h00);
    add_event(REQ_START, 8'hFF);
    for (i = 0; i < 5; i++) add_event(REQ_BYTE, pat_byte(FREEZE_ACK, i));
    // zero image length goes straight to resume
    for (i = 0; i < 5; i++) add_event(REQ_BYTE, (i % 2 == 1) ? 8'hFF : 8'h00);
    for (i = 0; i < 4; i++) add_event(REQ_BYTE, 8'h00);
    for (i = 0; i < 5; i++) add_event(REQ_BYTE, $urandom_range(0, 255));
    wait_quiet();

    reg_write(REG_SPARE, 16'($urandom_range(0, 65535)));
    reg_write(REG_CHUNK, 16'd0);
    reg_write(REG_REPLY, 16'd1);
    reg_write(REG_TAIL, 16'd1);
    random_phase(15);
    wait_quiet();

    reg_write(REG_CHUNK, 16'hFFFF);
    reg_write(REG_REPLY, 16'hFFFF);
    reg_write(REG_TAIL, 16'hFFFF);
    random_phase(15);
    wait_quiet();

    reg_write(REG_CHUNK, 16'($urandom_range(33, 100)));
    reg_write(REG_REPLY, 16'($urandom_range(2, 6)));
    reg_write(REG_TAIL, 16'($urandom_range(2, 6)));
    random_phase(15);
    wait_quiet();

    if (fail_count == 0)
      $display("serial_camera_jpeg_capture_reader_unit_tb passed");
    else
      $display("serial_camera_jpeg_capture_reader_unit_tb failed");
    $finish;
  end

  initial begin : watchdog
    #(64'd18_000_000);
    $display("serial_camera_jpeg_capture_reader_unit_tb failed");
    $finish;
  end

endmodule
